[rtl/core/ldfa_pkg.sv]
// Package for the lowest free descriptor allocator.
// Holds payload structs, fixed sizes, register indexes and the table growth rule.
// Used by ldfa_find and lowest_free_descriptor_allocator; ldfa_ram does not use it.
package ldfa_pkg;

  localparam int MAX_DESCRIPTORS = 1024;
  localparam int INITIAL_SIZE    = 64;
  localparam int GROW_UNIT       = 128;
  localparam int WORD_BITS       = 64;

  localparam int ROW_W      = 64;                       // bits per bitmap row
  localparam int MAP_ROWS   = MAX_DESCRIPTORS / ROW_W;
  localparam int ROW_IDX_W  = $clog2(MAP_ROWS);
  localparam int BIT_IDX_W  = $clog2(ROW_W);
  localparam int DESC_W     = 10;
  localparam int SIZE_W     = 11;
  localparam int GROW_W     = SIZE_W + 1;
  localparam int GROW_STEPS = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DESCRIPTOR_LIMIT = 2'd0,
    CFG_TABLE_CEILING    = 2'd1
  } cfg_index_e;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_TOO_MANY = 1'b1
  } status_e;

  typedef struct packed {
    logic [DESC_W-1:0] start_at;
    logic              exec_mark;
  } alloc_req_t;

  typedef struct packed {
    logic [DESC_W-1:0] descriptor;
    status_e           status;
    logic [SIZE_W-1:0] current_size;
  } alloc_rsp_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] idx;
  } find_t;

  // Smallest GROW_UNIT * 2^k that lies above the descriptor.
  function automatic logic [GROW_W-1:0] grow_size(input logic [SIZE_W-1:0] fd);
    logic [GROW_W-1:0] nsize;
    nsize = GROW_W'(GROW_UNIT);
    for (int i = 0; i < GROW_STEPS; i++) begin
      if (nsize <= {1'b0, fd}) begin
        nsize = nsize << 1;
      end
    end
    return nsize;
  endfunction

endpackage

[rtl/core/ldfa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ldfa_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ldfa_find.sv]
// First clear bit search over one bitmap row, with bits below a start offset masked when use_low_i is set.
// Depends on ldfa_pkg.
module ldfa_find (
  input  logic [ldfa_pkg::ROW_W-1:0]     row_i,
  input  logic                           use_low_i,
  input  logic [ldfa_pkg::BIT_IDX_W-1:0] low_bits_i,
  output ldfa_pkg::find_t                res_o
);

  logic [ldfa_pkg::ROW_W-1:0] masked;

  always_comb begin
    for (int i = 0; i < ldfa_pkg::ROW_W; i++) begin
      masked[i] = row_i[i] | (use_low_i && (ldfa_pkg::BIT_IDX_W'(i) < low_bits_i));
    end
  end

  // Walk from the top so the lowest clear bit wins.
  always_comb begin
    res_o = '0;
    for (int i = ldfa_pkg::ROW_W - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        res_o.found = 1'b1;
        res_o.idx   = ldfa_pkg::BIT_IDX_W'(i);
      end
    end
  end

endmodule

[rtl/core/lowest_free_descriptor_allocator.sv]
// Top level of the lowest free descriptor allocator: control, registers, row RAM.
// Depends on ldfa_pkg, ldfa_ram and ldfa_find.
//
//   channel | direction | handshake               | payload
//   in      | in        | in_valid_i / in_ready_o | in_data_i  (alloc_req_t)
//   out     | out       | out_valid_o/out_ready_i | out_data_o (alloc_rsp_t)
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A request scans the rows (1 to 16) in turn, one row of the RAM read port per cycle;
// a start at or above the table size skips the scan and goes straight to the decide step.
// Reset clears the per-row valid flags at once, so no clearing pass is needed.
// The result register holds a finished result while the next request is taken;
// a request whose result finds that register still full waits in its last step.
module lowest_free_descriptor_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ldfa_pkg::alloc_req_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output ldfa_pkg::alloc_rsp_t             out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ldfa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ldfa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int RowW   = ldfa_pkg::ROW_W;
  localparam int RamW   = 2 * ldfa_pkg::ROW_W;
  localparam int SizeW  = ldfa_pkg::SIZE_W;
  localparam int RowIdW = ldfa_pkg::ROW_IDX_W;
  localparam int BitIdW = ldfa_pkg::BIT_IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e                           state_q;
  logic [ldfa_pkg::DESC_W-1:0]      start_q;
  logic                             cloexec_q;
  logic [SizeW-1:0]                 s_q;
  logic [RowIdW-1:0]                row_q;
  logic                             first_q;
  logic [SizeW-1:0]                 fd_q;
  logic [RamW-1:0]                  data_q;
  logic                             rd_valid_q;
  logic [ldfa_pkg::MAP_ROWS-1:0]    row_valid_q;
  logic [SizeW-1:0]                 hint_q;
  logic [SizeW-1:0]                 size_q;
  logic [SizeW-1:0]                 limit_q;
  logic [SizeW-1:0]                 ceil_q;
  logic                             out_valid_q;
  ldfa_pkg::alloc_rsp_t             out_q;

  logic                             in_fire;
  logic [SizeW-1:0]                 s_start;
  logic [SizeW-BitIdW-1:0]          size_rows;
  logic [RowIdW:0]                  next_row;
  logic                             ram_re;
  logic [RowIdW-1:0]                ram_raddr;
  logic [RamW-1:0]                  ram_rdata;
  logic                             ram_we;
  logic [RowIdW-1:0]                ram_waddr;
  logic [RamW-1:0]                  ram_wdata;
  logic [RamW-1:0]                  scan_data;
  ldfa_pkg::find_t                  find_res;
  logic [SizeW-1:0]                 ceil_eff;
  logic [ldfa_pkg::GROW_W-1:0]      grown;
  logic [SizeW-1:0]                 ceil_round;
  logic [SizeW-1:0]                 capped;
  logic                             needs_grow;
  logic                             refused;
  logic [SizeW-1:0]                 new_size;
  logic                             out_free;
  logic                             commit;
  logic [RowW-1:0]                  bit_mask;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Search begins at the larger of the requested start and the hint.
  assign s_start   = ({1'b0, in_data_i.start_at} > hint_q) ? {1'b0, in_data_i.start_at}
                                                           : hint_q;
  assign size_rows = size_q[SizeW-1:BitIdW];
  assign next_row  = {1'b0, row_q} + (RowIdW+1)'(1);
  assign scan_data = rd_valid_q ? ram_rdata : '0;

  ldfa_find u_find (
    .row_i      (scan_data[RowW-1:0]),
    .use_low_i  (first_q),
    .low_bits_i (s_q[BitIdW-1:0]),
    .res_o      (find_res)
  );

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = row_q;
    if (state_q == ST_IDLE) begin
      ram_re    = in_fire && (s_start < size_q);
      ram_raddr = s_start[BitIdW +: RowIdW];
    end else if (state_q == ST_SCAN) begin
      ram_re    = !find_res.found && (next_row != size_rows);
      ram_raddr = next_row[RowIdW-1:0];
    end
  end

  // Growth rule: double from GROW_UNIT, then cap at the ceiling rounded up to a word.
  always_comb begin
    ceil_eff   = (ceil_q > SizeW'(ldfa_pkg::MAX_DESCRIPTORS))
                 ? SizeW'(ldfa_pkg::MAX_DESCRIPTORS) : ceil_q;
    grown      = ldfa_pkg::grow_size(fd_q);
    ceil_round = ((ceil_eff - SizeW'(1)) | SizeW'(ldfa_pkg::WORD_BITS - 1)) + SizeW'(1);
    capped     = (grown > {1'b0, ceil_eff}) ? ceil_round : grown[SizeW-1:0];
    needs_grow = (fd_q >= size_q);
    refused    = (fd_q >= limit_q) ||
                 (needs_grow && ((fd_q >= ceil_eff) || (capped <= fd_q)));
    new_size   = (!refused && needs_grow) ? capped : size_q;
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign commit    = (state_q == ST_DECIDE) && out_free;
  assign bit_mask  = RowW'(1) << fd_q[BitIdW-1:0];
  assign ram_we    = commit && !refused;
  assign ram_waddr = fd_q[BitIdW +: RowIdW];
  assign ram_wdata = {cloexec_q ? (data_q[RamW-1:RowW] | bit_mask)
                                : (data_q[RamW-1:RowW] & ~bit_mask),
                      data_q[RowW-1:0] | bit_mask};

  ldfa_ram #(
    .WIDTH (RamW),
    .DEPTH (ldfa_pkg::MAP_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= '0;
      cloexec_q   <= 1'b0;
      s_q         <= '0;
      row_q       <= '0;
      first_q     <= 1'b0;
      fd_q        <= '0;
      data_q      <= '0;
      rd_valid_q  <= 1'b0;
      row_valid_q <= '0;
      hint_q      <= '0;
      size_q      <= SizeW'(ldfa_pkg::INITIAL_SIZE);
      limit_q     <= SizeW'(1024);
      ceil_q      <= SizeW'(1024);
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (ldfa_pkg::cfg_index_e'(cfg_index_i))
          ldfa_pkg::CFG_DESCRIPTOR_LIMIT: limit_q <= cfg_data_i;
          ldfa_pkg::CFG_TABLE_CEILING:    ceil_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (ram_re) begin
        rd_valid_q <= row_valid_q[ram_raddr];
      end

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            start_q   <= in_data_i.start_at;
            cloexec_q <= in_data_i.exec_mark;
            s_q       <= s_start;
            row_q     <= s_start[BitIdW +: RowIdW];
            first_q   <= 1'b1;
            if (s_start < size_q) begin
              state_q <= ST_SCAN;
            end else begin
              // Rows beyond the table are always empty.
              fd_q    <= s_start;
              data_q  <= '0;
              state_q <= ST_DECIDE;
            end
          end
        end
        ST_SCAN: begin
          first_q <= 1'b0;
          if (find_res.found) begin
            fd_q    <= {row_q, find_res.idx};
            data_q  <= scan_data;
            state_q <= ST_DECIDE;
          end else if (next_row == size_rows) begin
            fd_q    <= size_q;
            data_q  <= '0;
            state_q <= ST_DECIDE;
          end else begin
            row_q <= next_row[RowIdW-1:0];
          end
        end
        ST_DECIDE: begin
          if (commit) begin
            out_q.current_size <= new_size;
            if (refused) begin
              out_q.descriptor <= '0;
              out_q.status     <= ldfa_pkg::STATUS_TOO_MANY;
            end else begin
              out_q.descriptor <= fd_q[ldfa_pkg::DESC_W-1:0];
              out_q.status     <= ldfa_pkg::STATUS_OK;
              size_q           <= new_size;
              row_valid_q[ram_waddr] <= 1'b1;
              if ({1'b0, start_q} <= hint_q) begin
                hint_q <= fd_q + SizeW'(1);
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_size_grows_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> size_q >= $past(size_q))
    else $error("table size shrank");

  a_size_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (size_q[BitIdW-1:0] == '0) && (size_q <= SizeW'(ldfa_pkg::MAX_DESCRIPTORS)))
    else $error("table size not a whole number of rows within bounds");

  a_alloc_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ldfa_pkg::STATUS_OK)
      |-> ({1'b0, out_data_o.descriptor} < out_data_o.current_size))
    else $error("allocated descriptor outside the table");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_write_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_DECIDE) && !ram_re)
    else $error("row write outside the commit step");

endmodule
